[src/sab_pkg.sv]
`default_nettype none
package sab_pkg;
    localparam int MaxLetters = 1024;
    localparam int Alphabet   = 26;
    localparam int StateCap   = 2 * MaxLetters - 1;
    localparam int StW        = $clog2(StateCap + 1);
    localparam int LetW       = 5;
    localparam int RowW       = $clog2(StateCap * Alphabet);
    localparam int ColW       = $clog2(Alphabet);

    localparam logic CmdAppend = 1'b0;
    localparam logic CmdQuery  = 1'b1;

    typedef struct packed {
        logic            cmd;
        logic [LetW-1:0] letter;
        logic            first;
    } t_in;

    typedef struct packed {
        logic        matched;
        logic [10:0] state_total;
        logic        overflow;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_CLR,
        S_WALK_RD,
        S_WALK_CHK,
        S_Q_LEN,
        S_Q_CHK,
        S_CP_RD,
        S_CP_WR,
        S_RED_RD,
        S_RED_CHK,
        S_QRY_RD,
        S_QRY_CHK,
        S_DONE
    } t_state;

    // Row base address of state s in the flat transition memory.
    function automatic logic [RowW-1:0] row_base(input logic [StW-1:0] s);
        row_base = RowW'(s) * RowW'(Alphabet);
    endfunction
endpackage
`default_nettype wire

[src/sab_ram.sv]
`default_nettype none
module sab_ram #(
    parameter int Depth = 2,
    parameter int Width = 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/suffix_automaton_builder_unit.sv]
// Channel   Signals                      Direction  Handshake
// command   i_start, o_busy, i_cmd_beat  in         beat taken when i_start && !o_busy
// result    o_done, o_res_beat           out        one-cycle strobe, no back-pressure
//
// A valid append with room left clears the new row one column at a time, then walks the suffix
// links, checks the target length, copies a row on a clone and walks the redirect steps.
// A query reads one transition, or none once the pattern has died. The single read port
// of the transition memory sets this pace. The result beat comes as o_busy drops.
// After reset a pass clears the root row with o_busy high.
// The result beat is shown for one cycle; the receiver cannot stall it.
`default_nettype none
module suffix_automaton_builder_unit
    import sab_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_cmd_beat,
    output logic      o_busy,
    output logic      o_done,
    output t_out      o_res_beat
);
    localparam int TDepth = StateCap * Alphabet;

    t_state r_st, n_st;
    t_in    r_in, n_in;
    logic [StW-1:0] r_last, n_last, r_used, n_used, r_cur, n_cur;
    logic [StW-1:0] r_r, n_r, r_q, n_q, r_k, n_k, r_p, n_p;
    logic           r_pnone, n_pnone, r_alive, n_alive;
    logic [ColW-1:0] r_col, n_col;
    logic [StW-1:0] r_lenp, n_lenp;
    logic           r_done, n_done;
    t_out           r_res, n_res;

    logic             t_we;
    logic [RowW-1:0]  t_wa, t_ra;
    logic [StW-1:0]   t_wd, t_rd;
    logic             l_we, k_we;
    logic [StW-1:0]   l_wa, l_ra, k_wa, k_ra;
    logic [StW:0]     l_wd, l_rd;
    logic [StW-1:0]   k_wd, k_rd;

    // transition memory (0 = none), suffix links ({none, idx}), lengths
    sab_ram #(.Depth(TDepth), .Width(StW)) u_tr (
        .i_clk, .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd), .i_raddr(t_ra), .o_rdata(t_rd));
    sab_ram #(.Depth(StateCap), .Width(StW + 1)) u_link (
        .i_clk, .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd), .i_raddr(l_ra), .o_rdata(l_rd));
    sab_ram #(.Depth(StateCap), .Width(StW)) u_len (
        .i_clk, .i_we(k_we), .i_waddr(k_wa), .i_wdata(k_wd), .i_raddr(k_ra), .o_rdata(k_rd));

    logic [RowW-1:0] c_pidx;
    assign c_pidx = row_base(r_p) + RowW'(r_in.letter);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT; r_last <= '0; r_used <= StW'(1); r_cur <= '0;
            r_alive <= 1'b1; r_done <= 1'b0; r_col <= '0;
        end else begin
            r_st <= n_st; r_last <= n_last; r_used <= n_used; r_cur <= n_cur;
            r_alive <= n_alive; r_done <= n_done; r_col <= n_col;
        end
        r_in <= n_in; r_r <= n_r; r_q <= n_q; r_k <= n_k; r_p <= n_p;
        r_pnone <= n_pnone; r_lenp <= n_lenp; r_res <= n_res;
    end

    always_comb begin
        n_st = r_st; n_in = r_in; n_last = r_last; n_used = r_used; n_cur = r_cur;
        n_r = r_r; n_q = r_q; n_k = r_k; n_p = r_p; n_pnone = r_pnone;
        n_alive = r_alive; n_col = r_col; n_lenp = r_lenp;
        n_done = 1'b0; n_res = r_res;
        t_we = 1'b0; t_wa = c_pidx; t_wd = '0; t_ra = c_pidx;
        l_we = 1'b0; l_wa = r_r; l_wd = '0; l_ra = r_p;
        k_we = 1'b0; k_wa = r_r; k_wd = '0; k_ra = r_p;
        unique case (r_st)
            S_INIT: begin
                t_we = 1'b1; t_wa = RowW'(r_col);
                l_we = 1'b1; l_wa = '0; l_wd = {1'b1, StW'(0)};
                k_we = 1'b1; k_wa = '0; k_wd = '0;
                n_col = r_col + 1'b1;
                if (r_col == ColW'(Alphabet - 1)) begin
                    n_col = '0; n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_in = i_cmd_beat;
                    n_res = '0;
                    if (i_cmd_beat.cmd == CmdQuery) begin
                        if (i_cmd_beat.first) begin
                            n_cur = '0; n_alive = 1'b1;
                        end
                        n_st = S_QRY_RD;
                    end else if (i_cmd_beat.letter >= LetW'(Alphabet)) begin
                        n_st = S_DONE;
                    end else if ({1'b0, r_used} + (StW+1)'(2) > (StW+1)'(StateCap)) begin
                        n_res.overflow = 1'b1; n_st = S_DONE;
                    end else begin
                        n_r = r_used; n_used = r_used + 1'b1; n_p = r_last;
                        n_pnone = 1'b0; n_col = '0; n_st = S_CLR;
                        k_ra = r_last;
                    end
                end
            end
            S_CLR: begin
                t_we = 1'b1; t_wa = row_base(r_r) + RowW'(r_col);
                if (r_col == '0) begin
                    k_we = 1'b1; k_wa = r_r; k_wd = k_rd + 1'b1;
                    l_we = 1'b1; l_wa = r_r; l_wd = '0;
                end
                n_col = r_col + 1'b1;
                if (r_col == ColW'(Alphabet - 1)) begin
                    n_col = '0; n_st = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (r_pnone) begin
                    n_last = r_r; n_st = S_DONE;
                end else begin
                    t_ra = c_pidx; l_ra = r_p; k_ra = r_p; n_st = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (t_rd == '0) begin
                    t_we = 1'b1; t_wa = c_pidx; t_wd = r_r;
                    n_p = l_rd[StW-1:0]; n_pnone = l_rd[StW]; n_st = S_WALK_RD;
                end else begin
                    n_q = t_rd; n_lenp = k_rd; n_st = S_Q_LEN;
                end
            end
            S_Q_LEN: begin
                k_ra = r_q; l_ra = r_q; n_st = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (r_lenp + 1'b1 == k_rd) begin
                    l_we = 1'b1; l_wa = r_r; l_wd = {1'b0, r_q};
                    n_last = r_r; n_st = S_DONE;
                end else begin
                    n_k = r_used; n_used = r_used + 1'b1;
                    k_we = 1'b1; k_wa = r_used; k_wd = r_lenp + 1'b1;
                    l_we = 1'b1; l_wa = r_used; l_wd = l_rd;
                    n_col = '0; n_st = S_CP_RD;
                end
            end
            S_CP_RD: begin
                t_ra = row_base(r_q) + RowW'(r_col); n_st = S_CP_WR;
            end
            S_CP_WR: begin
                t_we = 1'b1; t_wa = row_base(r_k) + RowW'(r_col); t_wd = t_rd;
                n_col = r_col + 1'b1; n_st = S_CP_RD;
                if (r_col == ColW'(Alphabet - 1)) begin
                    // Link the original target to the clone; the new state was linked to it at column 0.
                    l_we = 1'b1; l_wa = r_q; l_wd = {1'b0, r_k};
                    n_col = '0; n_st = S_RED_RD;
                end else if (r_col == '0) begin
                    l_we = 1'b1; l_wa = r_r; l_wd = {1'b0, r_k};
                end
            end
            S_RED_RD: begin
                if (r_pnone) begin
                    n_last = r_r; n_st = S_DONE;
                end else begin
                    t_ra = c_pidx; l_ra = r_p; n_st = S_RED_CHK;
                end
            end
            S_RED_CHK: begin
                if (t_rd == r_q) begin
                    t_we = 1'b1; t_wa = c_pidx; t_wd = r_k;
                    n_p = l_rd[StW-1:0]; n_pnone = l_rd[StW]; n_st = S_RED_RD;
                end else begin
                    n_last = r_r; n_st = S_DONE;
                end
            end
            S_QRY_RD: begin
                t_ra = row_base(r_cur) + RowW'(r_in.letter);
                if (!r_alive) begin
                    n_st = S_DONE;
                end else if (r_in.letter >= LetW'(Alphabet) || r_cur >= r_used) begin
                    n_alive = 1'b0; n_st = S_DONE;
                end else begin
                    n_st = S_QRY_CHK;
                end
            end
            S_QRY_CHK: begin
                if (t_rd == '0) begin
                    n_alive = 1'b0;
                end else begin
                    n_cur = t_rd;
                end
                n_st = S_DONE;
            end
            S_DONE: begin
                n_res.state_total = 11'(r_used);
                n_res.matched = (r_in.cmd == CmdQuery) && r_alive;
                n_done = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_busy     = (r_st != S_IDLE);
    assign o_done     = r_done;
    assign o_res_beat = r_res;

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used >= StW'(1) && r_used <= StW'(StateCap)) else $error("state count out of range");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");
    a_ovf_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res_beat.overflow |-> !o_res_beat.matched) else $error("overflow on query");
    a_used_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != S_INIT |=> r_used >= $past(r_used)) else $error("state count fell");
endmodule
`default_nettype wire
